@@ hdl/slns_pkg.sv @@
// Shared types and constants for the sorted line-number selector.
// Holds the request codes and the command and status bundles between controller and datapath.
// Depends on nothing.
`default_nettype none

package slns_pkg;

	localparam logic [1:0] REQ_ADD     = 2'd0;
	localparam logic [1:0] REQ_BYTE    = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	localparam logic [7:0]  NEWLINE  = 8'd10;
	localparam logic [31:0] LINE_MAX = 32'hFFFF_FFFF;
	localparam logic [31:0] LINE_ONE = 32'd1;

	typedef struct packed {
		logic accept_byte;
		logic restart;
		logic add_start;
		logic rd_idx;
		logic rd_pend;
		logic add_step;
		logic add_tail;
		logic byte_commit;
	} cmd_t;

	typedef struct packed {
		logic add_skip;
		logic idx_at_count;
		logic full;
		logic slot_eq;
		logic hit;
		logic out_busy;
	} status_t;

endpackage

`default_nettype wire

@@ hdl/slns_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the sorted slot store; depends on nothing.
`default_nettype none

module slns_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 wr_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                     wr_data,
	input  wire logic                                 rd_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                     rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/slns_datapath.sv @@
// Datapath of the sorted line-number selector: slot RAM, fill count, line counter and output register.
// Depends on slns_pkg and slns_ram.
`default_nettype none

module slns_datapath import slns_pkg::*; #(
	parameter int SLOT_COUNT = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output status_t          status,
	input  wire logic [31:0] line_number,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [7:0]  out_byte
);

	localparam int IW = $clog2(SLOT_COUNT + 1);
	localparam int AW = SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1;

	logic [IW-1:0] count_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] pend_q;
	logic [31:0]   line_q;
	logic          started_q;
	logic [31:0]   carry_q;
	logic [7:0]    byte_q;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [31:0]   rd_data;
	logic          slot_gt;
	logic          pend_valid;

	assign slot_gt    = rd_data > carry_q;
	assign pend_valid = pend_q < count_q;

	assign wr_en   = cmd.add_tail || (cmd.add_step && slot_gt);
	assign wr_addr = cmd.add_tail ? count_q[AW-1:0] : idx_q[AW-1:0];
	assign rd_en   = cmd.rd_idx || cmd.rd_pend;
	assign rd_addr = cmd.rd_pend ? pend_q[AW-1:0] : idx_q[AW-1:0];

	slns_ram #(
		.WIDTH(32),
		.DEPTH(SLOT_COUNT)
	) u_slots (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(carry_q),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		status.add_skip     = started_q || (line_number == 32'd0);
		status.idx_at_count = idx_q == count_q;
		status.full         = count_q == IW'(SLOT_COUNT);
		status.slot_eq      = rd_data == carry_q;
		status.hit          = pend_valid && (rd_data == line_q);
		status.out_busy     = out_valid_q && out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			pend_q      <= '0;
			line_q      <= LINE_ONE;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.restart) begin
				count_q   <= '0;
				pend_q    <= '0;
				line_q    <= LINE_ONE;
				started_q <= 1'b0;
			end
			if (cmd.add_start) begin
				idx_q <= '0;
			end
			if (cmd.add_step) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.add_tail) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.accept_byte) begin
				started_q <= 1'b1;
			end
			if (cmd.byte_commit) begin
				if (byte_q == NEWLINE) begin
					if (status.hit) begin
						pend_q <= pend_q + 1'b1;
					end
					if (line_q != LINE_MAX) begin
						line_q <= line_q + 32'd1;
					end
				end
				if (status.hit) begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add_start) begin
			carry_q <= line_number;
		end
		if (cmd.add_step && slot_gt) begin
			carry_q <= rd_data;
		end
		if (cmd.accept_byte) begin
			byte_q <= data_byte;
		end
		if (cmd.byte_commit && status.hit) begin
			out_byte_q <= byte_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;

endmodule

`default_nettype wire

@@ hdl/slns_ctrl.sv @@
// Controller state machine of the sorted line-number selector.
// Sequences the insertion walk and the byte lookup; depends on slns_pkg.
`default_nettype none

module slns_ctrl import slns_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] req_type,
	input  wire status_t    status,
	output cmd_t            cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD_RD,
		S_ADD_CMP,
		S_BYTE_RD,
		S_BYTE_EV
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_stall = state_q != S_IDLE;
	assign accept   = in_valid && (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req_type)
						REQ_ADD: begin
							if (!status.add_skip) begin
								cmd.add_start = 1'b1;
								state_d       = S_ADD_RD;
							end
						end
						REQ_BYTE: begin
							cmd.accept_byte = 1'b1;
							state_d         = S_BYTE_RD;
						end
						REQ_RESTART: begin
							cmd.restart = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			S_ADD_RD: begin
				if (status.idx_at_count) begin
					cmd.add_tail = !status.full;
					state_d      = S_IDLE;
				end else begin
					cmd.rd_idx = 1'b1;
					state_d    = S_ADD_CMP;
				end
			end
			S_ADD_CMP: begin
				if (status.slot_eq) begin
					state_d = S_IDLE;
				end else begin
					cmd.add_step = 1'b1;
					state_d      = S_ADD_RD;
				end
			end
			S_BYTE_RD: begin
				cmd.rd_pend = 1'b1;
				state_d     = S_BYTE_EV;
			end
			S_BYTE_EV: begin
				if (!(status.hit && status.out_busy)) begin
					cmd.byte_commit = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ hdl/sorted_line_number_selector_core.sv @@
// Top level of the sorted line-number selector.
// Joins slns_ctrl and slns_datapath; depends on slns_pkg.
//
// Add requests insert a line number into a sorted, duplicate-free set of SLOT_COUNT
// entries held in a single RAM, and text-byte requests pass through every byte of
// each selected line. One request is in work at a time. An add request walks the
// occupied entries through the single RAM read port, with a read step and a compare
// step per entry; an add that is ignored, a restart and an unused code are done
// at acceptance. A text byte passes three steps: acceptance, a read of the pending
// entry, and a compare step that delivers it. A byte of a selected line stays in
// that compare step for as long as the previous passed byte is still stalled at the
// output. The block accepts a new request while a passed byte still waits at the
// output.
`default_nettype none

module sorted_line_number_selector_core import slns_pkg::*; #(
	parameter int SLOT_COUNT = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [31:0] line_number,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [7:0]  out_byte
);

	cmd_t    cmd;
	status_t status;

	slns_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.status  (status),
		.cmd     (cmd)
	);

	slns_datapath #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.line_number(line_number),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte)
	);

endmodule

`default_nettype wire
